FILE: design/nsr_pkg.sv
`timescale 1ns / 1ps

package nsr_pkg;

  // Widths of the data path.
  localparam int DataW    = 32;
  localparam int IterW    = 6;
  localparam int ProdW    = 2 * DataW;           // est * est
  localparam int DvdW     = ProdW;               // |est^2 - S|
  localparam int DsrW     = DataW + 1;           // 2 * est
  // The quotient of one Newton step always stays below 2^48: the target S is
  // at most 2^48 and the divisor is at least 2.
  localparam int QuotW    = 48;
  localparam int FracW    = 16;                  // Q16.16 fraction bits
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  localparam logic [IterW-1:0] IterReset = 6'd25;

  // Register map, indexed by the word address bit of paddr.
  localparam logic RegIterCount = 1'b0;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/newton_square_root.sv
`timescale 1ns / 1ps

// Channel  | Direction | Contents
// ---------+-----------+-----------------------------------------------
// in_      | slave     | tdata[31:0] = radicand (unsigned Q16.16)
// out_     | master    | tdata[31:0] = root (unsigned Q16.16)
// cfg_     | APB       | 0x0: iteration_count [5:0], reset value 25
//
// Each Newton step runs the multiply and setup states, the shared one-bit-per-cycle
// divider until its done flag, and the update state. A result is loaded into the
// output register after iteration_count steps, once that register is free; a zero
// radicand skips the steps. in_tready returns in the cycle after the load.
// One radicand is processed at a time; a finished result waits in the output
// register while the next radicand is accepted. Reset is synchronous, active low.
module newton_square_root (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,     // [31:0] radicand
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,    // [31:0] root
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [nsr_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [nsr_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [nsr_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import nsr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SETUP,
    S_DIV,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t            state_r;
  logic [IterW-1:0]  iter_cfg_r;
  logic [IterW-1:0]  iter_left_r;
  logic [DataW-1:0]  rad_r;
  logic [DataW-1:0]  est_r;
  logic [ProdW-1:0]  sq_r;
  logic              ge_r;
  logic              out_tvalid_r;
  logic [DataW-1:0]  out_tdata_r;

  logic              in_fire;
  logic              cfg_wr;
  logic [DataW-1:0]  half;
  logic [ProdW-1:0]  target;
  logic              ge;
  logic [DvdW-1:0]   diff;
  logic              div_start;
  logic [QuotW-1:0]  quot;
  div_stat_t         div_stat;
  logic [DataW-1:0]  est_dec;
  logic [QuotW:0]    est_inc;
  logic [DataW-1:0]  est_cand;
  logic [DataW-1:0]  est_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign half      = in_tdata >> 1;

  // S = radicand << 16, a Q32.32 value to compare against est^2.
  assign target    = {{(ProdW - DataW - FracW){1'b0}}, rad_r, {FracW{1'b0}}};
  assign ge        = (sq_r >= target);
  assign diff      = ge ? (sq_r - target) : (target - sq_r);
  assign div_start = (state_r == S_SETUP);

  nsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff),
    .divisor  ({est_r, 1'b0}),
    .quotient (quot),
    .stat     (div_stat)
  );

  // On the way down the quotient never exceeds est/2, so the low bits suffice.
  assign est_dec  = est_r - quot[DataW-1:0];
  assign est_inc  = {{(QuotW + 1 - DataW){1'b0}}, est_r} + {1'b0, quot};
  assign est_cand = ge_r ? est_dec
                  : ((|est_inc[QuotW:DataW]) ? {DataW{1'b1}} : est_inc[DataW-1:0]);
  assign est_nxt  = (est_cand == '0) ? DataW'(1) : est_cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      iter_cfg_r   <= IterReset;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_paddr[CfgAddrW-1] == RegIterCount)) begin
        iter_cfg_r <= cfg_pwdata[IterW-1:0];
      end
      // In S_FINISH the output register is handled by the state itself.
      if (out_tvalid_r && out_tready && (state_r != S_FINISH)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            rad_r       <= in_tdata;
            iter_left_r <= iter_cfg_r;
            if (in_tdata == '0) begin
              est_r   <= '0;
              state_r <= S_FINISH;
            end else begin
              est_r   <= (half == '0) ? DataW'(1) : half;
              state_r <= (iter_cfg_r == '0) ? S_FINISH : S_MUL;
            end
          end
        end
        S_MUL: begin
          sq_r    <= ProdW'(est_r) * ProdW'(est_r);
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          ge_r    <= ge;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          est_r       <= est_nxt;
          iter_left_r <= iter_left_r - 1'b1;
          state_r     <= (iter_left_r == IterW'(1)) ? S_FINISH : S_MUL;
        end
        S_FINISH: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= est_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CfgAddrW-1] == RegIterCount)
                    ? {{(CfgDataW - IterW){1'b0}}, iter_cfg_r} : '0;

endmodule

FILE: design/nsr_div.sv
`timescale 1ns / 1ps

module nsr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nsr_pkg::DvdW-1:0]   dividend,
  input  logic [nsr_pkg::DsrW-1:0]   divisor,
  output logic [nsr_pkg::QuotW-1:0]  quotient,
  output nsr_pkg::div_stat_t         stat
);
  import nsr_pkg::*;

  localparam int CntW = $clog2(QuotW + 1);
  localparam int HiW  = DvdW - QuotW;

  logic [DsrW-1:0]  rem_r;
  logic [QuotW-1:0] shq_r;
  logic [DsrW-1:0]  dsr_r;
  logic [CntW-1:0]  cnt_r;
  logic             done_r;

  logic [DsrW:0]    trial;
  logic [DsrW:0]    trial_sub;
  logic             fits;

  // Restoring division, one quotient bit per cycle. The low dividend bits
  // shift out of shq_r as the quotient bits shift in.
  assign trial     = {rem_r, shq_r[QuotW-1]};
  assign trial_sub = trial - {1'b0, dsr_r};
  assign fits      = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CntW'(QuotW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // The upper dividend bits are below the divisor because the quotient fits.
      rem_r <= {{(DsrW - HiW){1'b0}}, dividend[DvdW-1:QuotW]};
      shq_r <= dividend[QuotW-1:0];
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? trial_sub[DsrW-1:0] : trial[DsrW-1:0];
      shq_r <= {shq_r[QuotW-2:0], fits};
    end
  end

  assign quotient  = shq_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

FILE: design/nsr_checker.sv
`timescale 1ns / 1ps

module nsr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [31:0]                    in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [31:0]                    out_tdata,
  input logic                           cfg_psel,
  input logic                           cfg_penable,
  input logic                           cfg_pwrite,
  input logic [nsr_pkg::CfgAddrW-1:0]   cfg_paddr,
  input logic [nsr_pkg::CfgDataW-1:0]   cfg_pwdata,
  input logic [nsr_pkg::CfgDataW-1:0]   cfg_prdata,
  input logic                           cfg_pready
);
  import nsr_pkg::*;

  logic cfg_wr_iter;
  assign cfg_wr_iter = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                       && (cfg_paddr[CfgAddrW-1] == RegIterCount);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The unit works on one radicand at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted while busy");

  // A zero radicand, accepted while the output is free, shows a zero root.
  a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata == '0) && (!out_tvalid || out_tready)
    |=> ##1 out_tvalid && (out_tdata == '0))
    else $error("zero radicand did not give zero");

  // The iteration count reads back as written.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cfg_wr_iter) && (cfg_paddr[CfgAddrW-1] == RegIterCount)
    |-> cfg_prdata == {{(CfgDataW - IterW){1'b0}}, $past(cfg_pwdata[IterW-1:0])})
    else $error("iteration count readback mismatch");

endmodule

bind newton_square_root nsr_checker u_nsr_checker (.*);
